// File: design/sm_pkg.sv
package sm_pkg;

  localparam int MAX_CLASSES = 16;
  localparam int IDX_W       = $clog2(MAX_CLASSES);
  localparam int CNT_W       = $clog2(MAX_CLASSES + 1);
  localparam int ROM_SIZE    = 4096;
  localparam int ROM_AW      = $clog2(ROM_SIZE);
  localparam int EXP_W       = 17;
  localparam int SUM_W       = IDX_W + EXP_W;
  localparam int NUM_W       = 34;
  localparam int DIV_CW      = $clog2(NUM_W + 1);

  localparam logic signed [15:0] LOGIT_MIN = 16'sh8000;
  localparam logic [EXP_W-1:0]   EXP_ONE   = 17'h10000;

  typedef struct packed {
    logic [CNT_W-1:0]   n;
    logic signed [15:0] mx;
    logic               drop;
    logic               bank;
  } desc_t;

  // Ratio between neighboring table entries, exp(-1/256) in unsigned Q0.64,
  // taken as 2^64 minus a truncated Taylor sum.
  function automatic logic [63:0] exp_step_const();
    logic [63:0] t;
    logic [63:0] s;
    t = 64'd1 << 56;
    s = 64'd0;
    for (int k = 1; k < 16; k++) begin
      if (t != 64'd0) begin
        if (k[0]) s = s + t;
        else      s = s - t;
        t = (t >> 8) / 64'(k + 1);
      end
    end
    return 64'd0 - s;
  endfunction

  localparam logic [63:0] EXP_C = exp_step_const();

endpackage

// File: design/softmax_normalizer.sv
// Softmax over vectors of signed Q8.8 logits, one logit per input word, the
// last marked by in_end_of_vector. After reset the block fills its
// 4096-entry exponent table; no logit is taken before that. Logits then
// load one per cycle into one of two banks while the vector queue has room.
// A closed vector passes through a two-deep queue to the back end, which
// does the exponent lookups and then runs a one-bit-per-cycle divider for
// each of the n results. The front end keeps loading up to two further
// vectors meanwhile. Logits beyond 16 per vector are dropped and the
// vector's results carry out_overflowed.
module softmax_normalizer import sm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_logit,
  input  logic               in_end_of_vector,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_probability,
  output logic [3:0]         out_class_index,
  output logic               out_final_result,
  output logic               out_overflowed
);

  logic              rom_done;
  logic              q_full, q_valid, q_push, q_pop;
  desc_t             push_desc, q_head;
  logic              rd_bank;
  logic [IDX_W-1:0]  rd_idx;
  logic [15:0]       rd_data;
  logic [ROM_AW-1:0] rom_addr;
  logic [EXP_W-1:0]  rom_data;

  sm_exp_rom u_rom (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rom_addr),
    .rd_data (rom_data),
    .done    (rom_done)
  );

  sm_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_logit         (in_logit),
    .in_end_of_vector (in_end_of_vector),
    .rom_done         (rom_done),
    .q_full           (q_full),
    .push             (q_push),
    .push_desc        (push_desc),
    .rd_bank          (rd_bank),
    .rd_idx           (rd_idx),
    .rd_data          (rd_data)
  );

  sm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (push_desc),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_head),
    .valid (q_valid)
  );

  sm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .rd_bank          (rd_bank),
    .rd_idx           (rd_idx),
    .rd_data          (rd_data),
    .rom_addr         (rom_addr),
    .rom_data         (rom_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_probability  (out_probability),
    .out_class_index  (out_class_index),
    .out_final_result (out_final_result),
    .out_overflowed   (out_overflowed)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("vector queue overrun");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("vector queue underrun");

  a_ready_after_table: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready || out_valid) |-> rom_done) else $error("activity before table fill");
`endif

endmodule

// File: design/sm_queue.sv
module sm_queue import sm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t din,
  output logic  full,
  input  logic  pop,
  output desc_t dout,
  output logic  valid
);

  desc_t      mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

// File: design/sm_front.sv
module sm_front import sm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_logit,
  input  logic               in_end_of_vector,
  input  logic               rom_done,
  input  logic               q_full,
  output logic               push,
  output desc_t              push_desc,
  input  logic               rd_bank,
  input  logic [IDX_W-1:0]   rd_idx,
  output logic [15:0]        rd_data
);

  // Two banks, so one vector can load while the back end reads the other.
  logic [15:0]        store_r [2][MAX_CLASSES];
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic signed [15:0] max_r, max_nxt;
  logic               drop_r, drop_nxt;
  logic               bank_r;
  logic               accept;
  logic               has_room;

  assign in_ready = rom_done && !q_full;
  assign accept   = in_valid && in_ready;
  assign has_room = (count_r < CNT_W'(MAX_CLASSES));

  always_comb begin
    count_nxt = count_r;
    max_nxt   = max_r;
    drop_nxt  = drop_r;
    if (has_room) begin
      count_nxt = count_r + CNT_W'(1);
      if (count_r == '0 || in_logit > max_r) max_nxt = in_logit;
    end else begin
      drop_nxt = 1'b1;
    end
  end

  assign push           = accept && in_end_of_vector;
  assign push_desc.n    = count_nxt;
  assign push_desc.mx   = max_nxt;
  assign push_desc.drop = drop_nxt;
  assign push_desc.bank = bank_r;

  always_ff @(posedge clk) begin
    if (accept && has_room) store_r[bank_r][count_r[IDX_W-1:0]] <= in_logit;
    rd_data <= store_r[rd_bank][rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      max_r   <= LOGIT_MIN;
      drop_r  <= 1'b0;
      bank_r  <= 1'b0;
    end else if (accept) begin
      if (in_end_of_vector) begin
        count_r <= '0;
        max_r   <= LOGIT_MIN;
        drop_r  <= 1'b0;
        bank_r  <= ~bank_r;
      end else begin
        count_r <= count_nxt;
        max_r   <= max_nxt;
        drop_r  <= drop_nxt;
      end
    end
  end

endmodule

// File: design/sm_exp_rom.sv
module sm_exp_rom import sm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ROM_AW-1:0] rd_addr,
  output logic [EXP_W-1:0]  rd_data,
  output logic              done
);

  // Entry i holds round(65536 * exp(-i/256)). After reset the table is
  // filled by repeated multiplication by EXP_C, one 32x32 partial product
  // per step.
  logic [EXP_W-1:0]  mem [ROM_SIZE];
  logic [ROM_AW-1:0] idx_r;
  logic [3:0]        st_r;
  logic              done_r;
  logic [63:0]       p_r;
  logic [127:0]      acc_r;
  logic [63:0]       prod_r;
  logic [31:0]       mul_a, mul_b;
  logic [127:0]      addend;
  logic              wr_en;
  logic [EXP_W-1:0]  wr_data;
  logic [64:0]       p_round;

  assign done    = done_r;
  assign wr_en   = !done_r && (st_r == 4'd0);
  assign p_round = {1'b0, p_r} + (65'd1 << 47);
  assign wr_data = (idx_r == '0) ? EXP_ONE : p_round[64:48];

  always_comb begin
    mul_a  = (st_r == 4'd5 || st_r == 4'd7) ? p_r[63:32] : p_r[31:0];
    mul_b  = (st_r == 4'd3 || st_r == 4'd7) ? EXP_C[63:32] : EXP_C[31:0];
    case (st_r)
      4'd2:    addend = {64'd0, prod_r};
      4'd8:    addend = {prod_r, 64'd0};
      default: addend = {32'd0, prod_r, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[idx_r] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!done_r) begin
      if (st_r == 4'd0 && idx_r == '0) p_r <= EXP_C;
      if (st_r == 4'd0) acc_r <= '0;
      if (st_r[0]) prod_r <= 64'(mul_a) * 64'(mul_b);
      if (st_r != 4'd0 && !st_r[0] && st_r != 4'd9) acc_r <= acc_r + addend;
      if (st_r == 4'd9) p_r <= acc_r[127:64] + 64'(acc_r[63]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      st_r   <= 4'd0;
      done_r <= 1'b0;
    end else if (!done_r) begin
      if (st_r == 4'd0) begin
        if (idx_r == '0) idx_r <= ROM_AW'(1);
        else if (idx_r == ROM_AW'(ROM_SIZE - 1)) done_r <= 1'b1;
        else st_r <= 4'd1;
      end else if (st_r == 4'd9) begin
        idx_r <= idx_r + ROM_AW'(1);
        st_r  <= 4'd0;
      end else begin
        st_r <= st_r + 4'd1;
      end
    end
  end

endmodule

// File: design/sm_back.sv
module sm_back import sm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  desc_t             q_head,
  output logic              q_pop,
  output logic              rd_bank,
  output logic [IDX_W-1:0]  rd_idx,
  input  logic [15:0]       rd_data,
  output logic [ROM_AW-1:0] rom_addr,
  input  logic [EXP_W-1:0]  rom_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_probability,
  output logic [3:0]        out_class_index,
  output logic              out_final_result,
  output logic              out_overflowed
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXP   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DIVL  = 3'd3;
  localparam logic [2:0] S_DIVR  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_PIPE  = 3'd6;

  logic [2:0]        state_r;
  desc_t             cur_r;
  logic [CNT_W-1:0]  i_r;
  logic [SUM_W-1:0]  sum_r;
  logic              pv0_r;
  logic [IDX_W-1:0]  pidx0_r;
  logic              pv_r;
  logic              pinr_r;
  logic [IDX_W-1:0]  pidx_r;
  logic [EXP_W-1:0]  exp_r [MAX_CLASSES];
  logic [NUM_W-1:0]  num_r;
  logic [SUM_W-1:0]  rem_r;
  logic [EXP_W-1:0]  q_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              out_valid_r;
  logic [15:0]       prob_r;
  logic [3:0]        cls_r;
  logic              fin_r;
  logic              ovf_r;

  logic signed [16:0] diff;
  logic               in_range;
  logic [EXP_W-1:0]   e_new;
  logic [SUM_W:0]     rem_sh;
  logic               ge;
  logic [SUM_W:0]     rem_sub;
  logic               is_last;
  logic               emit_fire;

  assign rd_bank  = cur_r.bank;
  assign rd_idx   = i_r[IDX_W-1:0];
  assign diff     = {cur_r.mx[15], cur_r.mx} - {rd_data[15], rd_data};
  assign in_range = !diff[16] && (diff[15:ROM_AW] == '0);
  assign rom_addr = diff[ROM_AW-1:0];
  assign e_new    = pinr_r ? rom_data : '0;

  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, sum_r});
  assign rem_sub = rem_sh - {1'b0, sum_r};

  assign is_last   = ((i_r + CNT_W'(1)) == cur_r.n);
  assign q_pop     = (state_r == S_DRAIN);
  assign emit_fire = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  assign out_valid        = out_valid_r;
  assign out_probability  = prob_r;
  assign out_class_index  = cls_r;
  assign out_final_result = fin_r;
  assign out_overflowed   = ovf_r;

  // The store read and the table lookup are each registered, so an exponent
  // passes through rd_data and then rom_data before it is written to exp_r.
  always_ff @(posedge clk) begin
    pidx0_r <= i_r[IDX_W-1:0];
    pinr_r  <= in_range;
    pidx_r  <= pidx0_r;
    if (pv_r) exp_r[pidx_r] <= e_new;
    if (state_r == S_IDLE) cur_r <= q_head;
    if (state_r == S_IDLE) sum_r <= '0;
    else if (pv_r) sum_r <= sum_r + SUM_W'(e_new);
    if (state_r == S_DIVL) begin
      num_r <= NUM_W'({exp_r[i_r[IDX_W-1:0]], 16'd0}) + NUM_W'(sum_r >> 1);
      rem_r <= '0;
      q_r   <= '0;
    end else if (state_r == S_DIVR) begin
      num_r <= num_r << 1;
      rem_r <= ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
      q_r   <= {q_r[EXP_W-2:0], ge};
    end
    if (emit_fire) begin
      if (sum_r == '0)   prob_r <= 16'd0;
      else if (q_r[16])  prob_r <= 16'hFFFF;
      else               prob_r <= q_r[15:0];
      cls_r <= 4'(i_r);
      fin_r <= is_last;
      ovf_r <= cur_r.drop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= '0;
      pv0_r       <= 1'b0;
      pv_r        <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pv0_r <= (state_r == S_EXP);
      pv_r  <= pv0_r;
      if (emit_fire)      out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            i_r     <= '0;
            state_r <= S_EXP;
          end
        end
        S_EXP: begin
          if (is_last) state_r <= S_PIPE;
          else         i_r <= i_r + CNT_W'(1);
        end
        S_PIPE: begin
          state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          i_r     <= '0;
          state_r <= S_DIVL;
        end
        S_DIVL: begin
          cnt_r   <= DIV_CW'(NUM_W);
          state_r <= S_DIVR;
        end
        S_DIVR: begin
          cnt_r <= cnt_r - DIV_CW'(1);
          if (cnt_r == DIV_CW'(1)) state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_fire) begin
            if (is_last) state_r <= S_IDLE;
            else begin
              i_r     <= i_r + CNT_W'(1);
              state_r <= S_DIVL;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import sm_pkg::*;

  localparam int LIMIT = 2_000_000;
  localparam int TAB_SIZE = 4096;

  typedef struct {
    logic signed [15:0] logit;
    logic               eov;
    logic               drain;
  } logit_word_t;

  typedef struct {
    logic [15:0] probability;
    logic [3:0]  class_index;
    logic        final_result;
    logic        overflowed;
  } prob_word_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_logit;
  logic               in_end_of_vector;
  logic               out_valid;
  logic               out_ready;
  logic [15:0]        out_probability;
  logic [3:0]         out_class_index;
  logic               out_final_result;
  logic               out_overflowed;

  softmax_normalizer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_logit(in_logit), .in_end_of_vector(in_end_of_vector),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_probability(out_probability), .out_class_index(out_class_index),
    .out_final_result(out_final_result), .out_overflowed(out_overflowed)
  );

  logit_word_t pending_logits[$];
  prob_word_t  expected_probs[$];

  // Predictor state.
  int unsigned exp_tab[TAB_SIZE];
  logic [15:0] vec_logits[MAX_CLASSES];
  int          vec_count;
  int          vec_max;
  logic        vec_dropped;

  int errors;
  int cycles;
  int words_sent;
  int probs_seen;
  int vectors_closed;
  int dropped_logits;
  int rx_seen;
  int tx_seen;
  int tx_gap;
  int rx_wait;
  int rx_hold;
  bit long_hold_done;
  bit burst_mode;

  function automatic logic [63:0] mul_hi_round(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << 63);
    return p[127:64];
  endfunction

  function automatic void build_exp_tab();
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] c;
    logic [63:0] p;
    int k;
    t = 64'd1 << 56;
    s = 64'd0;
    k = 1;
    while (t != 64'd0) begin
      if (k % 2 == 1) s = s + t;
      else s = s - t;
      k++;
      t = (t >> 8) / 64'(k);
    end
    c = 64'd0 - s;
    exp_tab[0] = 65536;
    p = c;
    for (int i = 1; i < TAB_SIZE; i++) begin
      exp_tab[i] = int'((p + (64'd1 << 47)) >> 48);
      p = mul_hi_round(p, c);
    end
  endfunction

  function automatic void reset_vector();
    vec_count = 0;
    vec_max = -32768;
    vec_dropped = 1'b0;
  endfunction

  // Folds one accepted logit into the vector and, on the end marker, queues
  // the probabilities the block should emit.
  function automatic void predict_softmax(logit_word_t w);
    longint unsigned sum;
    longint unsigned p;
    int unsigned e[MAX_CLASSES];
    int d;
    prob_word_t r;
    if (vec_count < MAX_CLASSES) begin
      vec_logits[vec_count] = w.logit;
      if (vec_count == 0 || int'(w.logit) > vec_max) vec_max = int'(w.logit);
      vec_count++;
    end else begin
      vec_dropped = 1'b1;
      dropped_logits++;
    end
    if (!w.eov) return;
    sum = 0;
    for (int i = 0; i < vec_count; i++) begin
      d = vec_max - int'($signed(vec_logits[i]));
      e[i] = (d >= 0 && d < TAB_SIZE) ? exp_tab[d] : 0;
      sum += e[i];
    end
    for (int i = 0; i < vec_count; i++) begin
      p = 0;
      if (sum != 0) begin
        p = (longint'(e[i]) * 65536 + (sum >> 1)) / sum;
        if (p > 65535) p = 65535;
      end
      r.probability = p[15:0];
      r.class_index = i[3:0];
      r.final_result = (i + 1 == vec_count);
      r.overflowed = vec_dropped;
      expected_probs.push_back(r);
    end
    vectors_closed++;
    reset_vector();
  endfunction

  function automatic void queue_word(logic signed [15:0] v, logic eov, logic drain);
    logit_word_t w;
    w.logit = v;
    w.eov = eov;
    w.drain = drain;
    pending_logits.push_back(w);
  endfunction

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    int n;
    int base;
    int v;
    int total;
    int vec_no;
    bit spread;
    in_valid = 1'b0;
    in_logit = '0;
    in_end_of_vector = 1'b0;
    out_ready = 1'b0;
    rst_n = 1'b0;
    errors = 0;
    cycles = 0;
    words_sent = 0;
    probs_seen = 0;
    vectors_closed = 0;
    dropped_logits = 0;
    rx_seen = 0;
    tx_seen = 0;
    tx_gap = 0;
    rx_wait = 0;
    rx_hold = 0;
    long_hold_done = 1'b0;
    burst_mode = 1'b0;
    build_exp_tab();
    reset_vector();

    // Directed: the two extremes together, a lone logit, differences at the
    // edge of the exponent table, and an overfull vector whose end marker
    // falls on a dropped logit.
    queue_word(16'sh7fff, 1'b0, 1'b0);
    queue_word(16'sh8000, 1'b1, 1'b0);
    queue_word(16'sd0, 1'b1, 1'b0);
    queue_word(16'sd256, 1'b0, 1'b0);
    queue_word(16'(256 - 4095), 1'b0, 1'b0);
    queue_word(16'(256 - 4096), 1'b0, 1'b0);
    queue_word(16'sd255, 1'b1, 1'b0);
    for (int i = 0; i < 18; i++) queue_word(16'(i * 37 - 300), i == 17, 1'b0);

    total = 25;
    vec_no = 0;
    while (total < 420) begin
      v = $urandom_range(0, 99);
      if (v < 85) n = $urandom_range(1, 8);
      else if (v < 95) n = $urandom_range(9, 16);
      else n = $urandom_range(17, 20);
      spread = 1'($urandom_range(0, 1));
      base = $urandom_range(0, 65535) - 32768;
      for (int i = 0; i < n; i++) begin
        if (spread) v = $urandom_range(0, 65535) - 32768;
        else begin
          v = base + $urandom_range(0, 4400) - 2200;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
        end
        // The first word of a few vectors waits until the block has drained.
        queue_word(16'(v), i == n - 1, i == 0 && (vec_no == 20 || vec_no == 55));
      end
      total += n;
      vec_no++;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (pending_logits.size() == 0 && !in_valid);
    wait (expected_probs.size() == 0);
    repeat (1000) @(posedge clk);
    if (expected_probs.size() != 0) begin
      $display("%0t: %0d probabilities never arrived", $time, expected_probs.size());
      errors++;
    end
    $display("Sent %0d logits in %0d vectors (%0d dropped past capacity);",
             words_sent, vectors_closed, dropped_logits);
    $display("checked %0d probabilities under random stalls on both sides.", probs_seen);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Acceptance on the input side feeds the predictor.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      logit_word_t w;
      w.logit = in_logit;
      w.eov = in_end_of_vector;
      w.drain = 1'b0;
      predict_softmax(w);
      words_sent++;
    end
  end

  // Sender: one new word at a time, a random gap before each.
  always @(negedge clk) begin
    logic nv;
    logit_word_t w;
    nv = in_valid;
    if (rst_n) begin
      if (nv && tx_seen != words_sent) begin
        nv = 1'b0;
        tx_seen = words_sent;
      end
      if (!nv) begin
        if (tx_gap > 0) tx_gap--;
        else if (pending_logits.size() > 0) begin
          if (!(pending_logits[0].drain && expected_probs.size() != 0)) begin
            w = pending_logits.pop_front();
            in_logit <= w.logit;
            in_end_of_vector <= w.eov;
            nv = 1'b1;
            if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
            tx_gap = burst_mode ? 0 : $urandom_range(0, 6);
          end
        end
      end
    end
    in_valid <= nv;
  end

  // Receiver: random stall per word, and one long hold to back the block up.
  always @(negedge clk) begin
    if (rst_n) begin
      if (rx_seen != probs_seen) begin
        rx_seen = probs_seen;
        rx_wait = burst_mode ? 0 : $urandom_range(0, 6);
        if (!long_hold_done && probs_seen >= 60) begin
          long_hold_done = 1'b1;
          rx_hold = 1500;
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    prob_word_t x;
    cycles++;
    if (cycles > LIMIT) begin
      $display("%0t: timed out after %0d cycles", $time, cycles);
      $display("status: fail");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      probs_seen++;
      if (expected_probs.size() == 0) begin
        $display("%0t: unexpected word, prob %0d idx %0d", $time, out_probability,
                 out_class_index);
        errors++;
      end else begin
        x = expected_probs.pop_front();
        if (out_probability !== x.probability) begin
          $display("%0t: probability expected %0d actual %0d", $time, x.probability,
                   out_probability);
          errors++;
        end
        if (out_class_index !== x.class_index) begin
          $display("%0t: class_index expected %0d actual %0d", $time, x.class_index,
                   out_class_index);
          errors++;
        end
        if (out_final_result !== x.final_result) begin
          $display("%0t: final_result expected %0b actual %0b", $time, x.final_result,
                   out_final_result);
          errors++;
        end
        if (out_overflowed !== x.overflowed) begin
          $display("%0t: overflowed expected %0b actual %0b", $time, x.overflowed,
                   out_overflowed);
          errors++;
        end
      end
    end
  end

endmodule
